FILE: design/pcs_pkg.sv
// Package: shared types and constants for the percentile color stretch block.
`default_nettype none
package pcs_pkg;

	localparam int NUM_CH      = 3;
	localparam int LEVELS_DEF  = 256;
	localparam int CNT_W       = 25;
	localparam int SUM_W       = 26;
	localparam int TH_W        = 25;
	localparam int LO_TH_W     = 21;
	localparam int PIX_W       = 8;
	localparam int SETTLE_W    = 2;

	localparam logic [CNT_W-1:0] PIX_COUNT_RST = CNT_W'(307200);
	localparam int PCT_FACTOR  = 20;
	// N/20 = (N>>2)/5, and x/5 = (x * ceil(2^26/5)) >> 26 for x < 2^23
	localparam int DIV4_SHIFT  = 2;
	localparam int DIV5_SHIFT  = 26;
	localparam int DIV5_MUL_W  = 24;
	localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = DIV5_MUL_W'(13421773);
	localparam int PROD_W      = CNT_W - DIV4_SHIFT + DIV5_MUL_W;
	localparam logic [SETTLE_W-1:0] SETTLE_CYC = SETTLE_W'(3);

	localparam logic ACT_HIST  = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	typedef struct packed {
		logic             action;
		logic [7:0]       bin_index;
		logic [CNT_W-1:0] blue_count;
		logic [CNT_W-1:0] green_count;
		logic [CNT_W-1:0] red_count;
		logic [PIX_W-1:0] pixel_blue;
		logic [PIX_W-1:0] pixel_green;
		logic [PIX_W-1:0] pixel_red;
	} pcs_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_blue;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_red;
	} pcs_out_t;

	typedef struct packed {
		logic       hist;
		logic       pix;
		logic [7:0] bin;
	} lane_ctl_t;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] value;
	} lane_stat_t;

	typedef enum logic [1:0] {
		LN_IDLE,
		LN_RUN,
		LN_DONE
	} lane_state_t;

endpackage
`default_nettype wire

FILE: design/pcs_thresh.sv
// Pixel count register and the 5% / 95% threshold pipeline.
`default_nettype none
module pcs_thresh import pcs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata,
	output logic      [TH_W-1:0]  lo_th,
	output logic      [TH_W-1:0]  hi_th,
	output logic                  settled
);

	logic [CNT_W-1:0]    pixel_count_q;
	logic [SETTLE_W-1:0] settle_q;
	logic [PROD_W-1:0]   prod_s1;
	logic [CNT_W-1:0]    n_s1;
	logic [TH_W-1:0]     lo_th_q;
	logic [TH_W-1:0]     hi_th_q;
	logic [LO_TH_W-1:0]  lo_val;
	logic [CNT_W-1:0]    lo_x20;
	logic [CNT_W-1:0]    rem20;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= PIX_COUNT_RST;
			settle_q      <= SETTLE_CYC;
		end else if (cfg_we) begin
			pixel_count_q <= cfg_wdata;
			settle_q      <= SETTLE_CYC;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(pixel_count_q[CNT_W-1:DIV4_SHIFT]) * PROD_W'(DIV5_MUL);
		n_s1    <= pixel_count_q;
	end

	always_comb begin
		lo_val = prod_s1[DIV5_SHIFT +: LO_TH_W];
		lo_x20 = CNT_W'(lo_val) * CNT_W'(PCT_FACTOR);
		rem20  = n_s1 - lo_x20;
	end

	// floor(19N/20) = N - ceil(N/20)
	always_ff @(posedge clk) begin
		lo_th_q <= TH_W'(lo_val);
		hi_th_q <= n_s1 - TH_W'(lo_val) - TH_W'(rem20 != '0);
	end

	assign lo_th   = lo_th_q;
	assign hi_th   = hi_th_q;
	assign settled = (settle_q == '0);

endmodule
`default_nettype wire

FILE: design/pcs_lane.sv
// One color channel: histogram level tracking and the iterative stretch divider.
`default_nettype none
module pcs_lane import pcs_pkg::*; #(
	parameter int LEVELS = LEVELS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lane_ctl_t        ctl,
	input  wire logic [CNT_W-1:0] count,
	input  wire logic [PIX_W-1:0] pix,
	input  wire logic [TH_W-1:0]  lo_th,
	input  wire logic [TH_W-1:0]  hi_th,
	input  wire logic             take,
	output lane_stat_t            stat
);

	localparam int QW  = $clog2(LEVELS) + 1;
	localparam int NW  = PIX_W + QW;
	localparam int SW  = $clog2(QW);
	localparam int LIM = (LEVELS - 1 > 255) ? 255 : LEVELS - 1;

	logic [SUM_W-1:0] low_sum_q, high_sum_q;
	logic [7:0]       low_level_q, high_level_q;
	logic [SUM_W-1:0] lo_base, hi_base, lo_sat, hi_sat;
	logic [SUM_W:0]   lo_add, hi_add;

	lane_state_t state_q, state_d;
	logic [NW-1:0]    rem_q;
	logic [PIX_W-1:0] den_q;
	logic [QW-1:0]    quot_q;
	logic [SW-1:0]    step_q;
	logic             flat_q;
	logic [NW-1:0]    trial;
	logic [PIX_W-1:0] xc;
	logic [QW-1:0]    quot_sat;

	always_comb begin
		lo_base = (ctl.bin == 8'd0) ? '0 : low_sum_q;
		hi_base = (ctl.bin == 8'd0) ? '0 : high_sum_q;
		lo_add  = {1'b0, lo_base} + (SUM_W+1)'(count);
		hi_add  = {1'b0, hi_base} + (SUM_W+1)'(count);
		lo_sat  = lo_add[SUM_W] ? '1 : lo_add[SUM_W-1:0];
		hi_sat  = hi_add[SUM_W] ? '1 : hi_add[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_sum_q    <= '0;
			high_sum_q   <= '0;
			low_level_q  <= '0;
			high_level_q <= 8'd255;
		end else if (ctl.hist) begin
			if (lo_base <= SUM_W'(lo_th)) begin
				low_sum_q   <= lo_sat;
				low_level_q <= ctl.bin;
			end else begin
				low_sum_q <= lo_base;
			end
			if (hi_base <= SUM_W'(hi_th)) begin
				high_sum_q   <= hi_sat;
				high_level_q <= ctl.bin;
			end else begin
				high_sum_q <= hi_base;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			LN_IDLE: if (ctl.pix) state_d = LN_RUN;
			LN_RUN:  if (step_q == '0) state_d = LN_DONE;
			LN_DONE: if (take) state_d = LN_IDLE;
			default: state_d = LN_IDLE;
		endcase
	end

	always_comb begin
		xc    = (pix > high_level_q) ? high_level_q : pix;
		xc    = (xc < low_level_q) ? low_level_q : xc;
		trial = NW'(den_q) << step_q;
	end

	// quotient never exceeds LEVELS, so QW restoring steps suffice
	always_ff @(posedge clk) begin
		if (state_q == LN_IDLE && ctl.pix) begin
			rem_q  <= NW'(xc - low_level_q) * NW'(LEVELS);
			den_q  <= high_level_q - low_level_q;
			flat_q <= (high_level_q <= low_level_q);
			quot_q <= '0;
			step_q <= SW'(QW - 1);
		end else if (state_q == LN_RUN) begin
			if (rem_q >= trial) begin
				rem_q          <= rem_q - trial;
				quot_q[step_q] <= 1'b1;
			end
			step_q <= step_q - 1'b1;
		end
	end

	always_comb begin
		quot_sat   = (quot_q > QW'(LIM)) ? QW'(LIM) : quot_q;
		stat.done  = (state_q == LN_DONE);
		stat.value = flat_q ? '0 : PIX_W'(quot_sat);
	end

endmodule
`default_nettype wire

FILE: design/percentile_color_stretch.sv
// Top level: handshakes, three channel lanes and the merged output register.
//
//  channel | signals                        | moves
//  src     | src_valid src_ready src_data   | histogram bin or pixel beat in
//  dst     | dst_valid dst_ready dst_data   | stretched pixel beat out
//  cfg     | cfg_we cfg_wdata               | pixel_count write, no wait
//
// A pixel beat goes through the per-lane restoring divider, one quotient bit a
// cycle, and holds src_ready low until the lanes' results are loaded. A pixel
// beat is taken while the previous result waits on dst. src_ready also stays
// low after reset and after each cfg write while thresholds are recomputed.
// A stalled dst holds the lanes' results.
`default_nettype none
module percentile_color_stretch import pcs_pkg::*; #(
	parameter int LEVELS = LEVELS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             src_valid,
	output logic                  src_ready,
	input  wire pcs_in_t          src_data,
	output logic                  dst_valid,
	input  wire logic             dst_ready,
	output pcs_out_t              dst_data,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata
);

	logic [TH_W-1:0]    lo_th, hi_th;
	logic               settled;
	logic               accept, load, busy_q, dst_valid_q;
	lane_ctl_t          ctl;
	lane_stat_t         stat [NUM_CH];
	logic [NUM_CH-1:0]  done_vec;
	logic [CNT_W-1:0]   counts [NUM_CH];
	logic [PIX_W-1:0]   pixels [NUM_CH];
	pcs_out_t           dst_data_q;

	pcs_thresh u_thresh (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.lo_th     (lo_th),
		.hi_th     (hi_th),
		.settled   (settled)
	);

	assign src_ready = settled && !busy_q;
	assign accept    = src_valid && src_ready;

	always_comb begin
		ctl.hist  = accept && (src_data.action == ACT_HIST);
		ctl.pix   = accept && (src_data.action == ACT_PIXEL);
		ctl.bin   = src_data.bin_index;
		counts[0] = src_data.blue_count;
		counts[1] = src_data.green_count;
		counts[2] = src_data.red_count;
		pixels[0] = src_data.pixel_blue;
		pixels[1] = src_data.pixel_green;
		pixels[2] = src_data.pixel_red;
	end

	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		pcs_lane #(
			.LEVELS (LEVELS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.count  (counts[c]),
			.pix    (pixels[c]),
			.lo_th  (lo_th),
			.hi_th  (hi_th),
			.take   (load),
			.stat   (stat[c])
		);
		assign done_vec[c] = stat[c].done;
	end

	assign load = (&done_vec) && (!dst_valid_q || dst_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			dst_valid_q <= 1'b0;
		end else begin
			if (ctl.pix) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				dst_valid_q <= 1'b1;
			end else if (dst_ready) begin
				dst_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dst_data_q.out_blue  <= stat[0].value;
			dst_data_q.out_green <= stat[1].value;
			dst_data_q.out_red   <= stat[2].value;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

endmodule
`default_nettype wire

FILE: tb/sv/percentile_color_stretch_checker.sv
// Checker: watches the src, dst and cfg ports, predicts each stretched pixel and compares.
`timescale 1ns / 100ps
module percentile_color_stretch_checker import pcs_pkg::*; #(
	parameter int LEVELS = LEVELS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             src_valid,
	input  logic             src_ready,
	input  pcs_in_t          src_data,
	input  logic             dst_valid,
	input  logic             dst_ready,
	input  pcs_out_t         dst_data,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             drained,
	output int               errors,
	output int               pending,
	output int               checked
);

	localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 1;

	logic [CNT_W-1:0] pix_total;
	logic [SUM_W-1:0] low_acc [NUM_CH];
	logic [SUM_W-1:0] high_acc [NUM_CH];
	logic [7:0]       low_lvl [NUM_CH];
	logic [7:0]       high_lvl [NUM_CH];
	pcs_out_t         stretched_q[$];
	int               err_count;
	int               beats_checked;
	bit               leftovers_done;

	task automatic log_error(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			log_error($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	function automatic logic [7:0] stretch_value(input logic [7:0] x, input logic [7:0] lo,
		input logic [7:0] hi);
		longint unsigned xc, v, lim;
		lim = (LEVELS - 1 > 255) ? 255 : LEVELS - 1;
		xc = x;
		if (xc > hi)
			xc = hi;
		if (xc < lo)
			xc = lo;
		if (hi <= lo)
			return 8'd0;
		v = ((xc - lo) * LEVELS) / (hi - lo);
		return 8'(v > lim ? lim : v);
	endfunction

	task automatic take_bin(input pcs_in_t d);
		longint unsigned n, lo_th, hi_th, s;
		logic [CNT_W-1:0] cnts [NUM_CH];
		n = pix_total;
		lo_th = n / PCT_FACTOR;
		hi_th = (n * PCT_FACTOR - n) / PCT_FACTOR;
		cnts[0] = d.blue_count;
		cnts[1] = d.green_count;
		cnts[2] = d.red_count;
		if (d.bin_index == 8'd0) begin
			for (int c = 0; c < NUM_CH; c++) begin
				low_acc[c] = '0;
				high_acc[c] = '0;
			end
		end
		for (int c = 0; c < NUM_CH; c++) begin
			if (low_acc[c] <= lo_th) begin
				s = low_acc[c] + cnts[c];
				low_acc[c] = SUM_W'(s > SUM_CAP ? SUM_CAP : s);
				low_lvl[c] = d.bin_index;
			end
			if (high_acc[c] <= hi_th) begin
				s = high_acc[c] + cnts[c];
				high_acc[c] = SUM_W'(s > SUM_CAP ? SUM_CAP : s);
				high_lvl[c] = d.bin_index;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		pcs_out_t want;
		if (!arst_n) begin
			pix_total = PIX_COUNT_RST;
			for (int c = 0; c < NUM_CH; c++) begin
				low_acc[c] = '0;
				high_acc[c] = '0;
				low_lvl[c] = 8'd0;
				high_lvl[c] = 8'd255;
			end
			stretched_q.delete();
			err_count = 0;
			beats_checked = 0;
			leftovers_done = 1'b0;
		end else begin
			if (cfg_we)
				pix_total = cfg_wdata;
			// results leave before new pixels join, a pixel never finishes in its own cycle
			if (dst_valid && dst_ready) begin
				if (stretched_q.size() == 0) begin
					log_error("result beat with no pixel waiting");
				end else begin
					want = stretched_q.pop_front();
					check_field("out_blue", dst_data.out_blue, want.out_blue);
					check_field("out_green", dst_data.out_green, want.out_green);
					check_field("out_red", dst_data.out_red, want.out_red);
					beats_checked++;
				end
			end
			if (src_valid && src_ready) begin
				if (src_data.action == ACT_PIXEL)
					stretched_q.push_back('{
						out_blue:  stretch_value(src_data.pixel_blue, low_lvl[0], high_lvl[0]),
						out_green: stretch_value(src_data.pixel_green, low_lvl[1], high_lvl[1]),
						out_red:   stretch_value(src_data.pixel_red, low_lvl[2], high_lvl[2])});
				else
					take_bin(src_data);
			end
			if (drained && !leftovers_done) begin
				leftovers_done = 1'b1;
				if (stretched_q.size() != 0)
					log_error($sformatf("%0d pixel results never arrived", stretched_q.size()));
			end
		end
		errors <= err_count;
		pending <= stretched_q.size();
		checked <= beats_checked;
	end

endmodule

FILE: tb/sv/percentile_color_stretch_test.sv
// Testbench top: clock, reset, stimulus for the percentile color stretch block, and verdict.
`timescale 1ns / 100ps
module percentile_color_stretch_test;
	import pcs_pkg::*;

	localparam int ITEMS = 1200;
	localparam int CALM_ITEMS = 150;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             src_valid = 1'b0;
	logic             src_ready;
	pcs_in_t          src_data = '0;
	logic             dst_valid;
	logic             dst_ready = 1'b1;
	pcs_out_t         dst_data;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             drained = 1'b0;
	int               errors;
	int               pending;
	int               checked;

	bit               calm = 1'b0;
	int               src_gap_odds = 3;
	int               sink_odds = 3;
	int               items_sent = 0;
	int               bins_sent = 0;
	int               pixels_sent = 0;
	int               cfg_writes = 0;
	longint unsigned  cur_count = 307200;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	percentile_color_stretch dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	percentile_color_stretch_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.drained   (drained),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	function automatic pcs_in_t noise_beat();
		pcs_in_t n;
		n.action = 1'($urandom());
		n.bin_index = 8'($urandom());
		n.blue_count = CNT_W'($urandom());
		n.green_count = CNT_W'($urandom());
		n.red_count = CNT_W'($urandom());
		n.pixel_blue = 8'($urandom());
		n.pixel_green = 8'($urandom());
		n.pixel_red = 8'($urandom());
		return n;
	endfunction

	function automatic pcs_in_t hist_beat(input logic [7:0] bin, input logic [CNT_W-1:0] b,
		input logic [CNT_W-1:0] g, input logic [CNT_W-1:0] r);
		pcs_in_t d;
		d = noise_beat();
		d.action = ACT_HIST;
		d.bin_index = bin;
		d.blue_count = b;
		d.green_count = g;
		d.red_count = r;
		return d;
	endfunction

	function automatic pcs_in_t pixel_beat(input logic [7:0] b, input logic [7:0] g,
		input logic [7:0] r);
		pcs_in_t d;
		d = noise_beat();
		d.action = ACT_PIXEL;
		d.pixel_blue = b;
		d.pixel_green = g;
		d.pixel_red = r;
		return d;
	endfunction

	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] bin_count(input int mode, input longint unsigned base);
		longint unsigned cap;
		case (mode)
			0, 1, 2: cap = 2 * base;
			3, 4: cap = ($urandom_range(0, 7) == 0) ? 8 * base : 0;
			default: cap = CNT_MAX;
		endcase
		if (cap > CNT_MAX)
			cap = CNT_MAX;
		return CNT_W'($urandom_range(0, 32'(cap)));
	endfunction

	task automatic send_beat(input pcs_in_t d);
		if (!calm && $urandom_range(0, 15) < src_gap_odds) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data <= d;
		@(posedge clk);
		while (!src_ready)
			@(posedge clk);
		items_sent++;
		if (d.action == ACT_PIXEL)
			pixels_sent++;
		else
			bins_sent++;
	endtask

	// only while idle: every pixel returned and the lanes given time to settle
	task automatic write_pixel_count(input logic [CNT_W-1:0] v);
		src_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_count = v;
		cfg_writes++;
	endtask

	task automatic run_histogram();
		int step_max;
		int bin;
		int mode;
		longint unsigned base;
		case ($urandom_range(0, 4))
			0: step_max = 1;
			1: step_max = 3;
			2: step_max = 8;
			3: step_max = 24;
			default: step_max = 64;
		endcase
		base = cur_count * (step_max + 1) / 512;
		mode = $urandom_range(0, 5);
		src_gap_odds = $urandom_range(0, 6);
		// mostly well-formed runs from bin 0, some start mid-histogram
		bin = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 255) : 0;
		while (bin <= 255 && items_sent < ITEMS) begin
			if ($urandom_range(0, 11) == 0)
				send_beat(noise_beat());
			send_beat(hist_beat(8'(bin), bin_count(mode, base), bin_count(mode, base),
				bin_count(mode, base)));
			bin += $urandom_range(1, step_max);
		end
		repeat ($urandom_range(3, 16))
			send_beat(pixel_beat(pick_pixel(), pick_pixel(), pick_pixel()));
	endtask

	initial begin
		int sink_tick;
		sink_tick = 0;
		forever begin
			@(posedge clk);
			sink_tick++;
			if (sink_tick % 200 == 0)
				sink_odds = $urandom_range(0, 5);
			if (!calm && $urandom_range(0, 15) < sink_odds) begin
				dst_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				dst_ready <= 1'b1;
			end
		end
	end

	initial begin
		int phase;
		phase = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// levels straight from reset
		send_beat(pixel_beat(8'd0, 8'd128, 8'd255));
		send_beat(pixel_beat(8'd255, 8'd255, 8'd255));
		// zero pixel count: both thresholds zero
		write_pixel_count('0);
		send_beat(hist_beat(8'd0, '0, CNT_W'(1), CNT_MAX));
		send_beat(hist_beat(8'd255, CNT_MAX, CNT_W'(16777216), '0));
		send_beat(pixel_beat(8'd0, 8'd255, 8'd77));
		// flat range, bins out of order, clamping at both levels
		write_pixel_count(CNT_W'(100));
		send_beat(hist_beat(8'd0, CNT_W'(100), CNT_W'(5), '0));
		send_beat(hist_beat(8'd9, '0, CNT_W'(1), CNT_W'(4)));
		send_beat(hist_beat(8'd3, '0, CNT_W'(90), CNT_W'(2)));
		send_beat(pixel_beat(8'd50, 8'd50, 8'd50));
		send_beat(hist_beat(8'd0, '0, '0, '0));
		send_beat(hist_beat(8'd40, CNT_W'(5), CNT_W'(2), CNT_W'(1)));
		send_beat(hist_beat(8'd200, CNT_W'(90), CNT_W'(3), CNT_W'(99)));
		send_beat(hist_beat(8'd255, CNT_W'(5), CNT_W'(95), '0));
		send_beat(pixel_beat(8'd0, 8'd0, 8'd0));
		send_beat(pixel_beat(8'd255, 8'd255, 8'd255));
		send_beat(pixel_beat(8'd40, 8'd120, 8'd200));
		send_beat(pixel_beat(8'd39, 8'd201, 8'd250));

		while (items_sent < ITEMS) begin
			case (phase)
				0: write_pixel_count(CNT_W'(1));
				1: write_pixel_count(CNT_W'(20));
				2: write_pixel_count(CNT_W'(16777216));
				3: write_pixel_count(CNT_MAX);
				4: write_pixel_count('0);
				5: write_pixel_count(PIX_COUNT_RST);
				default: write_pixel_count(CNT_W'($urandom_range(1, 16777216)));
			endcase
			phase++;
			repeat ($urandom_range(1, 3)) begin
				if (items_sent < ITEMS) begin
					calm = items_sent >= ITEMS - CALM_ITEMS;
					run_histogram();
				end
			end
		end

		src_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
		drained <= 1'b1;
		repeat (3) @(posedge clk);
		$display("Run covered %0d histogram beats and %0d pixel beats over %0d pixel_count values",
			bins_sent, pixels_sent, cfg_writes);
		$display("%0d stretched pixels compared, %0d mismatches", checked, errors);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
